// ===== sv/pls_pkg.sv =====
// Package for the positional list store: sizes, operation codes and the
// control word that the top level broadcasts to every storage cell.
// No dependencies.
package pls_pkg;

  localparam int CAPACITY  = 64;
  localparam int KEY_W     = 32;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int GRP_SIZE  = 8;
  localparam int GRP_OFF_W = $clog2(GRP_SIZE);
  localparam int NUM_GRP   = CAPACITY / GRP_SIZE;
  localparam int GRP_IDX_W = $clog2(NUM_GRP);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  // Broadcast to all cells during the execute cycle.
  typedef struct packed {
    logic             ins;    // committed insert
    logic             rem;    // committed remove
    logic             cmp;    // capture key match
    logic [IDX_W-1:0] pos;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] count;
  } ctrl_t;

endpackage

// ===== sv/positional_list_store_unit.sv =====
// Positional list store: an ordered list of signed keys in a row of cells.
// Depends on pls_pkg, pls_cell and pls_group_enc.
//
// One word in, one word out. Insert, remove and clear pass through accept,
// execute in the cell row and emit. Search adds a group stage and a merge
// stage, because the match flags pass through a two-level registered
// first-match tree (groups of eight, then across groups). The block holds
// one word at a time: s_axis_tready returns once the result is loaded into
// the output register, which may still wait for the consumer. A failed
// operation reports ok = 0 and leaves the list as it was.
module positional_list_store_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // key [31:0], position [37:32], zero [39:38]
  input  logic [1:0]  s_axis_tuser,  // operation [1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // ok [0], found_index [6:1], count [13:7], zero [15:14]
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_EXEC  = 5'b00010,
    ST_GROUP = 5'b00100,
    ST_MERGE = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_e;

  state_e                       state_q, state_d;
  pls_pkg::op_e                 op_q;
  logic [pls_pkg::KEY_W-1:0]    key_q;
  logic [pls_pkg::IDX_W-1:0]    pos_q;
  logic [pls_pkg::CNT_W-1:0]    count_q, count_d;
  logic                         res_ok_q, res_ok_d;
  logic [pls_pkg::IDX_W-1:0]    res_idx_q, res_idx_d;
  logic                         out_valid_q, out_valid_d;
  logic                         out_ok_q;
  logic [pls_pkg::IDX_W-1:0]    out_idx_q;
  logic [pls_pkg::CNT_W-1:0]    out_count_q;
  logic [pls_pkg::NUM_GRP-1:0]  grp_hit_q, grp_hit;
  logic [pls_pkg::GRP_OFF_W-1:0] grp_off_q [pls_pkg::NUM_GRP];
  logic [pls_pkg::GRP_OFF_W-1:0] grp_off [pls_pkg::NUM_GRP];

  logic [pls_pkg::KEY_W-1:0]    entry [pls_pkg::CAPACITY];
  logic [pls_pkg::CAPACITY-1:0] match;
  pls_pkg::ctrl_t               ctrl;

  logic in_fire, out_free, in_exec;
  logic ins_ok, rem_ok;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign in_exec  = (state_q == ST_EXEC);

  assign ins_ok = (op_q == pls_pkg::OP_INSERT) &&
                  (count_q < pls_pkg::CNT_W'(pls_pkg::CAPACITY)) &&
                  ({1'b0, pos_q} <= count_q);
  assign rem_ok = (op_q == pls_pkg::OP_REMOVE) && ({1'b0, pos_q} < count_q);

  always_comb begin
    ctrl.ins   = in_exec && ins_ok;
    ctrl.rem   = in_exec && rem_ok;
    ctrl.cmp   = in_exec;
    ctrl.pos   = pos_q;
    ctrl.key   = key_q;
    ctrl.count = count_q;
  end

  // Cell row: each cell sees its neighbors; key below cell 0, own entry above the last.
  for (genvar g = 0; g < pls_pkg::CAPACITY; g++) begin : g_cell
    logic [pls_pkg::KEY_W-1:0] left, right;
    if (g == 0) begin : g_first
      assign left = key_q;
    end else begin : g_inner_l
      assign left = entry[g-1];
    end
    if (g == pls_pkg::CAPACITY - 1) begin : g_last
      assign right = entry[g];
    end else begin : g_inner_r
      assign right = entry[g+1];
    end
    pls_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .idx_i   (pls_pkg::IDX_W'(g)),
      .left_i  (left),
      .right_i (right),
      .entry_o (entry[g]),
      .match_o (match[g])
    );
  end

  for (genvar k = 0; k < pls_pkg::NUM_GRP; k++) begin : g_grp
    pls_group_enc u_enc (
      .match_i (match[k*pls_pkg::GRP_SIZE +: pls_pkg::GRP_SIZE]),
      .hit_o   (grp_hit[k]),
      .off_o   (grp_off[k])
    );
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    res_ok_d    = res_ok_q;
    res_idx_d   = res_idx_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_idx_d = '0;
        res_ok_d  = 1'b0;
        unique case (op_q)
          pls_pkg::OP_INSERT: begin
            res_ok_d = ins_ok;
            if (ins_ok) begin
              count_d = count_q + pls_pkg::CNT_W'(1);
            end
            state_d = ST_EMIT;
          end
          pls_pkg::OP_REMOVE: begin
            res_ok_d = rem_ok;
            if (rem_ok) begin
              count_d = count_q - pls_pkg::CNT_W'(1);
            end
            state_d = ST_EMIT;
          end
          pls_pkg::OP_SEARCH: begin
            state_d = ST_GROUP;
          end
          pls_pkg::OP_CLEAR: begin
            res_ok_d = 1'b1;
            count_d  = '0;
            state_d  = ST_EMIT;
          end
          default: begin
            state_d = ST_EMIT;
          end
        endcase
      end
      ST_GROUP: begin
        state_d = ST_MERGE;
      end
      ST_MERGE: begin
        res_ok_d  = 1'b0;
        res_idx_d = '0;
        for (int k = pls_pkg::NUM_GRP - 1; k >= 0; k--) begin
          if (grp_hit_q[k]) begin
            res_ok_d  = 1'b1;
            res_idx_d = {pls_pkg::GRP_IDX_W'(k), grp_off_q[k]};
          end
        end
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q  <= pls_pkg::op_e'(s_axis_tuser);
      key_q <= s_axis_tdata[31:0];
      pos_q <= s_axis_tdata[32 +: pls_pkg::IDX_W];
    end
    res_ok_q  <= res_ok_d;
    res_idx_q <= res_idx_d;
    if (state_q == ST_GROUP) begin
      grp_hit_q <= grp_hit;
      grp_off_q <= grp_off;
    end
    if ((state_q == ST_EMIT) && out_free) begin
      out_ok_q    <= res_ok_q;
      out_idx_q   <= res_idx_q;
      out_count_q <= count_q;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_count_q, out_idx_q, out_ok_q};

  // The count never exceeds the store size.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= pls_pkg::CNT_W'(pls_pkg::CAPACITY))
    else $error("entry count beyond capacity");

  // An accepted word always goes straight to the execute cycle.
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_EXEC))
    else $error("accepted word did not reach execute");

  // A failed insert or remove, or a search, leaves the count alone.
  a_fail_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_exec && !ins_ok && !rem_ok && (op_q != pls_pkg::OP_CLEAR))
      |=> $stable(count_q))
    else $error("count changed on a failed operation or search");

  // A result is only loaded when the output register is free.
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_EMIT) && out_valid_q && !m_axis_tready) |=> (state_q == ST_EMIT))
    else $error("result emitted over a pending word");

endmodule

// ===== sv/pls_cell.sv =====
// One storage cell of the positional list store: holds one key, shifts
// toward either neighbor, and flags a key match. Depends on pls_pkg.
module pls_cell (
  input  logic                      clk_i,
  input  pls_pkg::ctrl_t            ctrl_i,
  input  logic [pls_pkg::IDX_W-1:0] idx_i,
  input  logic [pls_pkg::KEY_W-1:0] left_i,
  input  logic [pls_pkg::KEY_W-1:0] right_i,
  output logic [pls_pkg::KEY_W-1:0] entry_o,
  output logic                      match_o
);

  logic [pls_pkg::KEY_W-1:0] entry_q, entry_d;
  logic                      match_q, match_d;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      if (idx_i > ctrl_i.pos) begin
        entry_d = left_i;
      end else if (idx_i == ctrl_i.pos) begin
        entry_d = ctrl_i.key;
      end
    end else if (ctrl_i.rem && (idx_i >= ctrl_i.pos)) begin
      entry_d = right_i;
    end
  end

  // Only occupied cells may report a match.
  assign match_d = (entry_q == ctrl_i.key) &&
                   ({1'b0, idx_i} < ctrl_i.count);

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    if (ctrl_i.cmp) begin
      match_q <= match_d;
    end
  end

  assign entry_o = entry_q;
  assign match_o = match_q;

endmodule

// ===== sv/pls_group_enc.sv =====
// First-match encoder over one group of cell match flags.
// Depends on pls_pkg.
module pls_group_enc (
  input  logic [pls_pkg::GRP_SIZE-1:0]  match_i,
  output logic                          hit_o,
  output logic [pls_pkg::GRP_OFF_W-1:0] off_o
);

  always_comb begin
    hit_o = 1'b0;
    off_o = '0;
    // Walk downward so the lowest set flag wins.
    for (int i = pls_pkg::GRP_SIZE - 1; i >= 0; i--) begin
      if (match_i[i]) begin
        hit_o = 1'b1;
        off_o = pls_pkg::GRP_OFF_W'(i);
      end
    end
  end

endmodule
